// ===== hw/rtl/ctt_pkg.sv =====
package ctt_pkg;

	typedef enum logic [3:0] {
		KIND_EOL      = 4'd0,
		KIND_COMMENT  = 4'd1,
		KIND_EQUAL    = 4'd2,
		KIND_IDENT    = 4'd3,
		KIND_STRING   = 4'd4,
		KIND_LPAREN   = 4'd5,
		KIND_RPAREN   = 4'd6,
		KIND_LBRACKET = 4'd7,
		KIND_RBRACKET = 4'd8,
		KIND_COMMA    = 4'd9,
		KIND_END      = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	localparam logic [7:0]  LIMIT_RESET = 8'd10;
	localparam logic [15:0] LEN_MAX     = 16'hFFFF;

	localparam logic [7:0] CH_NUL       = 8'd0;
	localparam logic [7:0] CH_LF        = 8'd10;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_UNDERLINE = 8'h5F;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
		       (b >= 8'h30 && b <= 8'h39);
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alnum(b) || b == CH_UNDERLINE || b == CH_DOT ||
		       b == CH_STAR || b == CH_MINUS;
	endfunction

endpackage

// ===== hw/rtl/ctt_scan.sv =====
module ctt_scan import ctt_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic [7:0] limit,
	output push_t      push
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_COMMENT
	} mode_t;

	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [15:0]              start_q, start_d;
	logic [15:0]              len_q, len_d;
	logic                     nonempty_q, nonempty_d;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [15:0]              pos16;
	logic [15:0]              len_grown;
	logic                     close_v;
	token_t                   close_tok;
	logic                     own_v;
	token_t                   own_tok;
	logic                     go_idle;

	assign pos_inc   = pos_q + POSITION_BITS'(1);
	assign pos16     = 16'(pos_q);
	assign len_grown = (len_q == LEN_MAX) ? LEN_MAX : len_q + 16'd1;

	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_q;
		start_d    = start_q;
		len_d      = len_q;
		nonempty_d = nonempty_q;
		close_v    = 1'b0;
		close_tok  = '{kind: KIND_COMMENT, start: start_q, length: len_q, last: 1'b0};
		own_v      = 1'b0;
		own_tok    = '{kind: KIND_EOL, start: pos16, length: 16'd1, last: 1'b1};
		go_idle    = 1'b1;

		unique case (mode_q)
			MODE_WORD: begin
				if (is_word(byte_in)) begin
					go_idle = 1'b0;
					len_d   = len_grown;
					pos_d   = pos_inc;
				end else begin
					close_v        = 1'b1;
					close_tok.kind = ({8'd0, limit} >= len_q) ? KIND_IDENT : KIND_STRING;
				end
			end
			MODE_COMMENT: begin
				if (byte_in != CH_LF && byte_in != CH_NUL) begin
					go_idle = 1'b0;
					len_d   = len_grown;
					pos_d   = pos_inc;
				end else begin
					close_v = 1'b1;
				end
			end
			default: ;
		endcase

		if (go_idle) begin
			mode_d = MODE_IDLE;
			if (byte_in == CH_NUL) begin
				own_v          = nonempty_q;
				own_tok.kind   = KIND_END;
				own_tok.length = 16'd0;
				pos_d          = '0;
				start_d        = '0;
				len_d          = '0;
				nonempty_d     = 1'b0;
			end else begin
				nonempty_d = 1'b1;
				pos_d      = pos_inc;
				unique case (byte_in)
					CH_LF:       begin own_v = 1'b1; own_tok.kind = KIND_EOL;      end
					CH_EQUAL:    begin own_v = 1'b1; own_tok.kind = KIND_EQUAL;    end
					CH_LPAREN:   begin own_v = 1'b1; own_tok.kind = KIND_LPAREN;   end
					CH_RPAREN:   begin own_v = 1'b1; own_tok.kind = KIND_RPAREN;   end
					CH_LBRACKET: begin own_v = 1'b1; own_tok.kind = KIND_LBRACKET; end
					CH_RBRACKET: begin own_v = 1'b1; own_tok.kind = KIND_RBRACKET; end
					CH_COMMA:    begin own_v = 1'b1; own_tok.kind = KIND_COMMA;    end
					CH_SEMICOLON, CH_SLASH: begin
						mode_d  = MODE_COMMENT;
						start_d = pos16;
						len_d   = 16'd1;
					end
					default: begin
						if (is_alnum(byte_in) || byte_in == CH_STAR) begin
							mode_d  = MODE_WORD;
							start_d = pos16;
							len_d   = 16'd1;
						end
					end
				endcase
			end
		end

		close_tok.last = !own_v;
	end

	always_comb begin
		push.count = 2'd0;
		push.tok0  = own_tok;
		push.tok1  = own_tok;
		if (step) begin
			if (close_v) begin
				push.tok0  = close_tok;
				push.count = own_v ? 2'd2 : 2'd1;
			end else begin
				push.count = own_v ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pos_q      <= '0;
			start_q    <= '0;
			len_q      <= '0;
			nonempty_q <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			pos_q      <= pos_d;
			start_q    <= start_d;
			len_q      <= len_d;
			nonempty_q <= nonempty_d;
		end
	end

endmodule

// ===== hw/rtl/ctt_queue.sv =====
module ctt_queue import ctt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   room,
	output logic   nonempty,
	output token_t head
);

	localparam int DEPTH = 4;

	token_t     data_q [DEPTH];
	token_t     data_d [DEPTH];
	logic [2:0] count_q;
	logic [2:0] base;

	assign nonempty = (count_q != 3'd0);
	assign room     = (count_q <= 3'd2);
	assign head     = data_q[0];
	assign base     = count_q - {2'd0, pop};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (pop && i < DEPTH - 1) begin
				data_d[i] = data_q[i+1];
			end else begin
				data_d[i] = data_q[i];
			end
			if (push.count != 2'd0 && base == 3'(i)) begin
				data_d[i] = push.tok0;
			end
			if (push.count == 2'd2 && base + 3'd1 == 3'(i)) begin
				data_d[i] = push.tok1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			data_q[i] <= data_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else begin
			count_q <= base + {1'b0, push.count};
		end
	end

endmodule

// ===== hw/rtl/config_text_tokenizer.sv =====
// Scans configuration text one source byte per item on the slave stream and
// emits one result item per token on the master stream: kind in tuser, start
// position and length in tdata, and tlast on the final token caused by a byte.
// A zero byte ends the source and yields an end token unless the source was
// empty. Each byte passes an input register, is classified combinationally against
// the scanner state and leaves its zero, one or two tokens in a four-entry
// result queue; a byte is taken in every cycle while the queue holds at most two
// tokens, and tokens leave at one per cycle while m_tready is high, so bytes that
// close a word or comment and also make a token of their own leave two tokens.
module config_text_tokenizer import ctt_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // identifier_length_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // source_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // token_start [15:0], token_length [31:16]
	output logic [3:0]  m_tuser,     // token_kind
	output logic        m_tlast      // last_of_run
);

	logic [7:0] limit_q;
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       step;
	logic       room;
	push_t      push;
	token_t     head;

	assign step     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	ctt_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.limit   (limit_q),
		.push    (push)
	);

	ctt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (m_tvalid && m_tready),
		.room     (room),
		.nonempty (m_tvalid),
		.head     (head)
	);

	assign m_tdata = {head.length, head.start};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
